>>> hdl/tls_pkg.sv
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer package
// Lamp codes, cycle constants and display enable patterns.
// ----------------------------------------------------------------------------
package tls_pkg;

	typedef enum logic [1:0] {
		LAMP_OFF    = 2'd0,
		LAMP_RED    = 2'd1,
		LAMP_YELLOW = 2'd2,
		LAMP_GREEN  = 2'd3
	} lamp_t;

	localparam logic [5:0] CycleLen  = 6'd38;
	localparam logic [5:0] FirstHalf = 6'd15;

	localparam logic [3:0] StepTicksReset = 4'd2;
	localparam logic [1:0] StepFirst      = 2'd3;

	localparam logic [3:0] EnAuto     = 4'd0;
	localparam logic [3:0] EnToTwo    = 4'd12;
	localparam logic [3:0] EnToOne    = 4'd3;
	localparam logic [3:0] EnSettled  = 4'd15;

endpackage

>>> hdl/tls_if.sv
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer channels
// Tick channel (switches in) and lamp channel (lamps and display out).
// ----------------------------------------------------------------------------
interface tls_tick_if;
	logic valid;
	logic ready;
	logic mode_switch;
	logic side_switch;

	modport source (output valid, output mode_switch, output side_switch, input ready);
	modport sink   (input valid, input mode_switch, input side_switch, output ready);
endinterface

interface tls_lamp_if;
	logic       valid;
	logic       ready;
	logic [1:0] lamp_one;
	logic [1:0] lamp_two;
	logic [1:0] tens_digit;
	logic [3:0] units_digit;
	logic [3:0] digit_enables;

	modport source (output valid, output lamp_one, output lamp_two, output tens_digit,
		output units_digit, output digit_enables, input ready);
	modport sink   (input valid, input lamp_one, input lamp_two, input tens_digit,
		input units_digit, input digit_enables, output ready);
endinterface

>>> hdl/two_way_traffic_light_sequencer_top.sv
// Path: input reg, then single-pass next-state decode, then result reg.
// Throughput: one tick transaction per cycle while the lamp channel takes results.
// A stalled result holds while one more tick waits in the input register.
// Reset (arst_n low): automatic mode, cycle start, step time 2 ticks, channels empty.
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer
// Automatic 38-tick cycle with countdown display and sticky manual mode.
// ----------------------------------------------------------------------------
module two_way_traffic_light_sequencer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	tls_tick_if.sink   tick,
	tls_lamp_if.source lamps
);
	import tls_pkg::*;

	logic       valid_s1;
	logic       mode_s1;
	logic       side_s1;
	logic       advance;

	logic [3:0] step_ticks_q;
	logic       in_manual_q;
	logic [5:0] auto_pos_q;
	logic       manual_side_q;
	logic       manual_busy_q;
	logic [1:0] manual_step_q;
	logic [3:0] step_left_q;

	logic       out_valid_q;
	lamp_t      lamp_one_q;
	lamp_t      lamp_two_q;
	logic [1:0] tens_q;
	logic [3:0] units_q;
	logic [3:0] en_q;

	logic       manual_n;
	logic [5:0] pos;
	logic [5:0] pos_n;
	logic       side_n;
	logic       busy_n;
	logic [1:0] step_n;
	logic [3:0] left_n;
	logic [3:0] reload;
	logic [4:0] count;
	lamp_t      l1;
	lamp_t      l2;
	logic [1:0] tens;
	logic [3:0] units;
	logic [3:0] en;

	assign advance    = !out_valid_q || lamps.ready;
	assign tick.ready = !valid_s1 || advance;

	always_comb begin
		pos      = (auto_pos_q >= CycleLen) ? 6'd0 : auto_pos_q;
		pos_n    = pos;
		manual_n = in_manual_q;
		side_n   = manual_side_q;
		busy_n   = manual_busy_q;
		step_n   = manual_step_q;
		left_n   = step_left_q;
		reload   = (step_ticks_q == 4'd0) ? 4'd1 : step_ticks_q;
		count    = 5'd0;
		l1       = LAMP_RED;
		l2       = LAMP_RED;
		tens     = 2'd0;
		units    = 4'd0;
		en       = EnSettled;
		if (!manual_n && pos == 6'd0 && mode_s1) begin
			manual_n = 1'b1;
			side_n   = side_s1;
			busy_n   = 1'b1;
			step_n   = StepFirst;
			left_n   = reload;
		end
		if (!manual_n) begin
			if (pos < FirstHalf) begin
				count = 5'(FirstHalf - pos);
				l1    = LAMP_RED;
				l2    = (count <= 5'd3) ? LAMP_YELLOW : LAMP_GREEN;
			end else begin
				count = 5'(CycleLen - pos);
				l1    = (count <= 5'd3) ? LAMP_YELLOW : LAMP_GREEN;
				l2    = LAMP_RED;
			end
			if (count >= 5'd20) begin
				tens  = 2'd2;
				units = 4'(count - 5'd20);
			end else if (count >= 5'd10) begin
				tens  = 2'd1;
				units = 4'(count - 5'd10);
			end else begin
				tens  = 2'd0;
				units = count[3:0];
			end
			en    = EnAuto;
			pos_n = (pos + 6'd1 >= CycleLen) ? 6'd0 : pos + 6'd1;
		end else begin
			if (!busy_n && side_s1 != side_n) begin
				side_n = side_s1;
				busy_n = 1'b1;
				step_n = StepFirst;
				left_n = reload;
			end
			if (busy_n) begin
				if (side_n) begin
					l1 = LAMP_YELLOW;
					l2 = LAMP_RED;
					en = EnToTwo;
				end else begin
					l1 = LAMP_RED;
					l2 = LAMP_YELLOW;
					en = EnToOne;
				end
				tens  = 2'd0;
				units = {2'd0, step_n};
				if (left_n <= 4'd1) begin
					if (step_n <= 2'd1) begin
						busy_n = 1'b0;
						left_n = 4'd0;
					end else begin
						step_n = step_n - 2'd1;
						left_n = reload;
					end
				end else begin
					left_n = left_n - 4'd1;
				end
			end else begin
				l1 = side_n ? LAMP_RED : LAMP_GREEN;
				l2 = side_n ? LAMP_GREEN : LAMP_RED;
				en = EnSettled;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= StepTicksReset;
		end else if (cfg_wr_en) begin
			step_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			mode_s1 <= tick.mode_switch;
			side_s1 <= tick.side_switch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_manual_q   <= 1'b0;
			auto_pos_q    <= 6'd0;
			manual_side_q <= 1'b0;
			manual_busy_q <= 1'b1;
			manual_step_q <= StepFirst;
			step_left_q   <= 4'd0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				in_manual_q   <= manual_n;
				auto_pos_q    <= pos_n;
				manual_side_q <= side_n;
				manual_busy_q <= busy_n;
				manual_step_q <= step_n;
				step_left_q   <= left_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			lamp_one_q <= l1;
			lamp_two_q <= l2;
			tens_q     <= tens;
			units_q    <= units;
			en_q       <= en;
		end
	end

	assign lamps.valid         = out_valid_q;
	assign lamps.lamp_one      = lamp_one_q;
	assign lamps.lamp_two      = lamp_two_q;
	assign lamps.tens_digit    = tens_q;
	assign lamps.units_digit   = units_q;
	assign lamps.digit_enables = en_q;

	a_manual_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		in_manual_q |=> in_manual_q)
		else $error("manual mode dropped without reset");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		auto_pos_q < CycleLen)
		else $error("auto position out of range");

	a_settle_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(manual_busy_q) |-> $past(in_manual_q) && $past(step_left_q) <= 4'd1)
		else $error("manual transition ended early");

	a_one_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lamp_one_q == LAMP_RED || lamp_two_q == LAMP_RED))
		else $error("no direction shows red");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer testbench
// Runs the automatic cycle, enters manual mode and steps through side changes
// at several step times. Every tick transaction is mirrored in a local light
// model, and each lamp transaction is compared field by field with the frame
// that model predicted.
// ----------------------------------------------------------------------------
module tb;
	import tls_pkg::*;

	typedef struct packed {
		lamp_t      one;
		lamp_t      two;
		logic [1:0] tens;
		logic [3:0] units;
		logic [3:0] en;
	} lamp_frame_t;

	localparam int StallLimit = 2000;
	localparam int PrintLimit = 60;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;

	tls_tick_if tick_bus ();
	tls_lamp_if lamp_bus ();

	two_way_traffic_light_sequencer_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.tick        (tick_bus),
		.lamps       (lamp_bus)
	);

	always #1 clk = ~clk;

	// light model state
	logic [3:0] step_ticks = StepTicksReset;
	bit         in_manual = 1'b0;
	logic [5:0] auto_pos = '0;
	bit         man_side = 1'b0;
	bit         man_busy = 1'b1;
	logic [1:0] man_step = StepFirst;
	logic [3:0] ticks_left = '0;

	lamp_frame_t pending_frames[$];
	int          mismatches = 0;
	int          send_idle_pct = 6;
	int          recv_idle_pct = 66;
	int          quiet_cycles = 0;
	bit          req_side = 1'b0;

	function automatic logic [3:0] step_len();
		return (step_ticks == 4'd0) ? 4'd1 : step_ticks;
	endfunction

	function automatic void begin_transition(input bit side);
		man_side = side;
		man_busy = 1'b1;
		man_step = StepFirst;
		ticks_left = step_len();
	endfunction

	function automatic lamp_frame_t advance_lights(input bit mode, input bit side);
		lamp_frame_t f;
		logic [5:0]  count;
		logic [1:0]  st;
		if (auto_pos >= CycleLen) auto_pos = '0;
		if (!in_manual && auto_pos == 6'd0 && mode) begin
			in_manual = 1'b1;
			begin_transition(side);
		end
		if (!in_manual) begin
			if (auto_pos < FirstHalf) begin
				count = FirstHalf - auto_pos;
				f.one = LAMP_RED;
				if (count <= 6'd3) f.two = LAMP_YELLOW;
				else f.two = LAMP_GREEN;
			end else begin
				count = CycleLen - auto_pos;
				if (count <= 6'd3) f.one = LAMP_YELLOW;
				else f.one = LAMP_GREEN;
				f.two = LAMP_RED;
			end
			f.tens = 2'(count / 6'd10);
			f.units = 4'(count % 6'd10);
			f.en = EnAuto;
			auto_pos = (auto_pos + 6'd1 >= CycleLen) ? 6'd0 : auto_pos + 6'd1;
		end else begin
			if (!man_busy && side != man_side) begin_transition(side);
			if (man_busy) begin
				st = man_step;
				if (man_side) begin
					f.one = LAMP_YELLOW;
					f.two = LAMP_RED;
					f.en = EnToTwo;
				end else begin
					f.one = LAMP_RED;
					f.two = LAMP_YELLOW;
					f.en = EnToOne;
				end
				f.tens = 2'd0;
				f.units = {2'b00, st};
				if (ticks_left <= 4'd1) begin
					if (st <= 2'd1) begin
						man_busy = 1'b0;
						ticks_left = '0;
					end else begin
						man_step = st - 2'd1;
						ticks_left = step_len();
					end
				end else begin
					ticks_left = ticks_left - 4'd1;
				end
			end else begin
				if (man_side) begin
					f.one = LAMP_RED;
					f.two = LAMP_GREEN;
				end else begin
					f.one = LAMP_GREEN;
					f.two = LAMP_RED;
				end
				f.tens = 2'd0;
				f.units = 4'd0;
				f.en = EnSettled;
			end
		end
		return f;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PrintLimit)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic send_tick(input bit mode, input bit side);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.mode_switch <= mode;
		tick_bus.side_switch <= side;
		do @(posedge clk); while (!tick_bus.ready);
		pending_frames.push_back(advance_lights(mode, side));
	endtask

	task automatic drain_lamps();
		tick_bus.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_step_ticks(input logic [3:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		step_ticks = value;
	endtask

	// mode is held low at each cycle start so the automatic cycle keeps running
	task automatic test_auto_cycle(input int n);
		repeat (n)
			send_tick((auto_pos == 6'd0) ? 1'b0 : 1'($urandom_range(1)),
				1'($urandom_range(1)));
	endtask

	task automatic test_manual_entry();
		bit s;
		s = 1'($urandom_range(1));
		while (auto_pos != 6'd0) send_tick(1'b0, 1'($urandom_range(1)));
		send_tick(1'b1, s);
		repeat (5) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (2) send_tick(1'b1, s);
		repeat (6) send_tick(1'b0, ~s);
		send_tick(1'b1, ~s);
		req_side = ~s;
	endtask

	task automatic test_step_time(input logic [3:0] ticks, input int n);
		drain_lamps();
		write_step_ticks(ticks);
		repeat (n) begin
			if ($urandom_range(5) == 0) req_side = ~req_side;
			send_tick(1'($urandom_range(1)), req_side);
		end
	endtask

	initial begin : lamp_sink
		lamp_frame_t want;
		lamp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && lamp_bus.valid && lamp_bus.ready) begin
				if (pending_frames.size() == 0) begin
					report_mismatch("unexpected lamp transaction", 1, 0);
				end else begin
					want = pending_frames.pop_front();
					if (lamp_bus.lamp_one !== want.one)
						report_mismatch("lamp_one", lamp_bus.lamp_one, want.one);
					if (lamp_bus.lamp_two !== want.two)
						report_mismatch("lamp_two", lamp_bus.lamp_two, want.two);
					if (lamp_bus.tens_digit !== want.tens)
						report_mismatch("tens_digit", lamp_bus.tens_digit, want.tens);
					if (lamp_bus.units_digit !== want.units)
						report_mismatch("units_digit", lamp_bus.units_digit, want.units);
					if (lamp_bus.digit_enables !== want.en)
						report_mismatch("digit_enables", lamp_bus.digit_enables, want.en);
				end
			end
			lamp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((tick_bus.valid && tick_bus.ready) || (lamp_bus.valid && lamp_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		tick_bus.valid <= 1'b0;
		tick_bus.mode_switch <= 1'b0;
		tick_bus.side_switch <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_idle_pct = 66;
		test_auto_cycle(76);
		test_manual_entry();
		test_step_time(4'd0, 120);

		send_idle_pct = 66;
		recv_idle_pct = 6;
		test_step_time(4'd15, 120);
		test_step_time(4'($urandom_range(14, 1)), 60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_step_time(4'd1, 80);

		drain_lamps();
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

>>> two_way_traffic_light_sequencer_top.f
hdl/tls_pkg.sv
hdl/tls_if.sv
hdl/two_way_traffic_light_sequencer_top.sv
bench/tb.sv
